### sv/pmc_pkg.sv
// ============================================================================
// PS/2 mouse packet cursor package
// Types and constants shared by the packet framer, the cursor stage and the
// top level.
// ============================================================================
package pmc_pkg;

  // Widths fixed by the field definitions.
  localparam int BYTE_W    = 8;
  localparam int COORD_W   = 12;
  localparam int LIMIT_W   = 12;
  localparam int CFG_IDX_W = 2;
  localparam int DELTA_W   = 9;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_X_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LIMIT = 2'd1;

  // Reset values.
  localparam logic [LIMIT_W-1:0] X_LIMIT_RST = 12'd1024;
  localparam logic [LIMIT_W-1:0] Y_LIMIT_RST = 12'd768;
  localparam int                 POS_X_RST   = 512;
  localparam int                 POS_Y_RST   = 384;

  // Header byte bit positions.
  localparam int HDR_LEFT_BIT   = 0;
  localparam int HDR_RIGHT_BIT  = 1;
  localparam int HDR_MIDDLE_BIT = 2;
  localparam int HDR_SYNC_BIT   = 3;
  localparam int HDR_XSIGN_BIT  = 4;
  localparam int HDR_YSIGN_BIT  = 5;
  localparam int HDR_XOVF_BIT   = 6;
  localparam int HDR_YOVF_BIT   = 7;

  // Framing position within a three-byte packet.
  typedef enum logic [2:0] {
    FR_HEADER = 3'b001,
    FR_XDELTA = 3'b010,
    FR_YDELTA = 3'b100
  } pmc_frame_e;

  // One assembled packet, handed from the framer to the cursor stage.
  typedef struct packed {
    logic [BYTE_W-1:0] header;
    logic [BYTE_W-1:0] x_delta;
    logic [BYTE_W-1:0] y_delta;
  } pmc_pkt_t;

  // One result word.
  typedef struct packed {
    logic               packet_status;
    logic [COORD_W-1:0] cursor_x;
    logic [COORD_W-1:0] cursor_y;
    logic               left_pressed;
    logic               right_pressed;
    logic               middle_pressed;
  } pmc_result_t;

endpackage

### sv/pmc_if.sv
// ============================================================================
// PS/2 mouse packet cursor channel interfaces
// Valid/ready channels for received bytes, result words and register writes.
// ============================================================================

// Received byte channel.
interface pmc_byte_if;
  logic                       valid;
  logic                       ready;
  logic [pmc_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel.
interface pmc_result_if;
  logic                        valid;
  logic                        ready;
  logic                        packet_status;
  logic [pmc_pkg::COORD_W-1:0] cursor_x;
  logic [pmc_pkg::COORD_W-1:0] cursor_y;
  logic                        left_pressed;
  logic                        right_pressed;
  logic                        middle_pressed;

  modport source (output valid, output packet_status, output cursor_x, output cursor_y,
                  output left_pressed, output right_pressed, output middle_pressed,
                  input ready);
  modport sink   (input valid, input packet_status, input cursor_x, input cursor_y,
                  input left_pressed, input right_pressed, input middle_pressed,
                  output ready);
endinterface

// Configuration write channel.
interface pmc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pmc_pkg::CFG_IDX_W-1:0] index;
  logic [pmc_pkg::LIMIT_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/ps2_mouse_packet_cursor_top.sv
// ============================================================================
// PS/2 mouse packet cursor
// Assembles three-byte PS/2 mouse movement packets and keeps a clamped
// cursor position and button state.
// ============================================================================
//
//  Channel  Direction  Word                         Notes
//  rx_i     in         rx_byte                      one received mouse byte
//  res_o    out        status, cursor X/Y, buttons  one word per third byte
//  cfg_i    in         index, data                  X and Y limits, always ready
//
//  A byte is taken every cycle unless a stalled third byte holds the input
//  register. Each byte is registered there; the third byte of a packet is
//  then applied to the cursor and the result word appears on res_o in the
//  following cycle. Both stages advance whenever the output register is empty
//  or being read, so a stalled res_o backs up into rx_i only when a third
//  byte arrives. Reset clears the framing, sets the cursor to 512,384 with
//  all buttons released, and loads limits 1024 and 768.
//
module ps2_mouse_packet_cursor_top #(
  parameter int POS_BITS = 12
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pmc_byte_if.sink     rx_i,
  pmc_result_if.source res_o,
  pmc_cfg_if.sink      cfg_i
);

  logic [pmc_pkg::LIMIT_W-1:0] x_limit_q;
  logic [pmc_pkg::LIMIT_W-1:0] y_limit_q;
  pmc_pkg::pmc_pkt_t           pkt;
  logic                        pkt_valid;
  logic                        pkt_ready;

  // Limit registers; writes to unknown indexes are ignored.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_limit_q <= pmc_pkg::X_LIMIT_RST;
      y_limit_q <= pmc_pkg::Y_LIMIT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        pmc_pkg::CFG_X_LIMIT: x_limit_q <= cfg_i.data;
        pmc_pkg::CFG_Y_LIMIT: y_limit_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Byte register and packet framing.
  pmc_framer u_framer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_i),
    .pkt_o       (pkt),
    .pkt_valid_o (pkt_valid),
    .pkt_ready_i (pkt_ready)
  );

  // Cursor update and result register.
  pmc_cursor #(
    .POS_BITS (POS_BITS)
  ) u_cursor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pkt_i       (pkt),
    .pkt_valid_i (pkt_valid),
    .pkt_ready_o (pkt_ready),
    .x_limit_i   (x_limit_q),
    .y_limit_i   (y_limit_q),
    .res_o       (res_o)
  );

endmodule

### sv/pmc_framer.sv
// ============================================================================
// PS/2 mouse packet framer
// Registers each received byte and assembles header, X and Y delta bytes
// into one packet, dropping bytes without the sync bit while it waits for
// a header.
// ============================================================================
module pmc_framer (
  input  logic               clk_i,
  input  logic               rst_ni,
  pmc_byte_if.sink           rx_i,
  output pmc_pkg::pmc_pkt_t  pkt_o,
  output logic               pkt_valid_o,
  input  logic               pkt_ready_i
);

  logic [pmc_pkg::BYTE_W-1:0] byte_q;
  logic                       byte_valid_q;
  pmc_pkg::pmc_frame_e        frame_q, frame_d;
  logic [pmc_pkg::BYTE_W-1:0] header_q, header_d;
  logic [pmc_pkg::BYTE_W-1:0] xdelta_q, xdelta_d;
  logic                       is_last;
  logic                       advance;

  // The third byte of a packet needs room downstream; the others never wait.
  always_comb begin
    case (frame_q)
      pmc_pkg::FR_HEADER: is_last = 1'b0;
      pmc_pkg::FR_XDELTA: is_last = 1'b0;
      default:            is_last = 1'b1;
    endcase
  end

  assign advance     = byte_valid_q && (!is_last || pkt_ready_i);
  assign rx_i.ready  = !byte_valid_q || advance;
  assign pkt_valid_o = byte_valid_q && is_last;
  assign pkt_o       = '{header: header_q, x_delta: xdelta_q, y_delta: byte_q};

  // Framing state update for the byte at the head of the input register.
  always_comb begin
    frame_d  = frame_q;
    header_d = header_q;
    xdelta_d = xdelta_q;
    if (advance) begin
      case (frame_q)
        pmc_pkg::FR_HEADER: begin
          if (byte_q[pmc_pkg::HDR_SYNC_BIT]) begin
            header_d = byte_q;
            frame_d  = pmc_pkg::FR_XDELTA;
          end
        end
        pmc_pkg::FR_XDELTA: begin
          xdelta_d = byte_q;
          frame_d  = pmc_pkg::FR_YDELTA;
        end
        default: begin
          frame_d = pmc_pkg::FR_HEADER;
        end
      endcase
    end
  end

  // Input register and framing state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
      frame_q      <= pmc_pkg::FR_HEADER;
      header_q     <= '0;
      xdelta_q     <= '0;
    end else begin
      frame_q  <= frame_d;
      header_q <= header_d;
      xdelta_q <= xdelta_d;
      if (rx_i.ready) begin
        byte_valid_q <= rx_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      byte_q <= rx_i.rx_byte;
    end
  end

endmodule

### sv/pmc_cursor.sv
// ============================================================================
// PS/2 mouse packet cursor stage
// Applies one packet to the cursor position and button state, clamps each
// coordinate to its limit, and holds the result word in an output register.
// ============================================================================
module pmc_cursor #(
  parameter int POS_BITS = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pmc_pkg::pmc_pkt_t           pkt_i,
  input  logic                        pkt_valid_i,
  output logic                        pkt_ready_o,
  input  logic [pmc_pkg::LIMIT_W-1:0] x_limit_i,
  input  logic [pmc_pkg::LIMIT_W-1:0] y_limit_i,
  pmc_result_if.source                res_o
);

  // Sum width covers the position plus or minus a nine-bit delta.
  localparam int SumW = POS_BITS + 2;
  localparam int LimW = (POS_BITS > pmc_pkg::LIMIT_W) ? POS_BITS : pmc_pkg::LIMIT_W;
  localparam int ExtW = (POS_BITS > pmc_pkg::COORD_W) ? POS_BITS : pmc_pkg::COORD_W;
  localparam logic [POS_BITS-1:0] PosMax  = {POS_BITS{1'b1}};
  localparam logic [POS_BITS-1:0] PosXRst = POS_BITS'(pmc_pkg::POS_X_RST);
  localparam logic [POS_BITS-1:0] PosYRst = POS_BITS'(pmc_pkg::POS_Y_RST);

  logic [POS_BITS-1:0]         pos_x_q, pos_x_d;
  logic [POS_BITS-1:0]         pos_y_q, pos_y_d;
  logic [2:0]                  buttons_q, buttons_d;
  logic                        res_valid_q;
  logic                        status_q;
  logic                        status_d;
  logic                        take;
  logic                        overflow;
  logic [pmc_pkg::DELTA_W-1:0] dx;
  logic [pmc_pkg::DELTA_W-1:0] dy;
  logic [SumW-1:0]             sum_x;
  logic [SumW-1:0]             sum_y;
  logic [LimW-1:0]             x_lim_ext;
  logic [LimW-1:0]             y_lim_ext;
  logic [POS_BITS-1:0]         x_lim;
  logic [POS_BITS-1:0]         y_lim;
  logic [ExtW-1:0]             x_ext;
  logic [ExtW-1:0]             y_ext;

  assign take        = pkt_valid_i && pkt_ready_o;
  assign pkt_ready_o = !res_valid_q || res_o.ready;

  // Limits above the cursor range saturate to the largest position.
  assign x_lim_ext = LimW'(x_limit_i);
  assign y_lim_ext = LimW'(y_limit_i);
  assign x_lim     = (x_lim_ext > LimW'(PosMax)) ? PosMax : x_lim_ext[POS_BITS-1:0];
  assign y_lim     = (y_lim_ext > LimW'(PosMax)) ? PosMax : y_lim_ext[POS_BITS-1:0];

  // Nine-bit deltas take their sign from the header.
  assign dx       = {pkt_i.header[pmc_pkg::HDR_XSIGN_BIT], pkt_i.x_delta};
  assign dy       = {pkt_i.header[pmc_pkg::HDR_YSIGN_BIT], pkt_i.y_delta};
  assign overflow = pkt_i.header[pmc_pkg::HDR_XOVF_BIT] || pkt_i.header[pmc_pkg::HDR_YOVF_BIT];

  // X moves right with the delta; Y moves the other way.
  assign sum_x = {2'b00, pos_x_q} + {{(SumW - pmc_pkg::DELTA_W){dx[pmc_pkg::DELTA_W-1]}}, dx};
  assign sum_y = {2'b00, pos_y_q} - {{(SumW - pmc_pkg::DELTA_W){dy[pmc_pkg::DELTA_W-1]}}, dy};

  // Next cursor state, clamped to zero and the limit; an overflow packet leaves it unchanged.
  always_comb begin
    pos_x_d   = pos_x_q;
    pos_y_d   = pos_y_q;
    buttons_d = buttons_q;
    status_d  = overflow;
    if (!overflow) begin
      if (sum_x[SumW-1]) begin
        pos_x_d = '0;
      end else if (sum_x[SumW-2:0] > {1'b0, x_lim}) begin
        pos_x_d = x_lim;
      end else begin
        pos_x_d = sum_x[POS_BITS-1:0];
      end
      if (sum_y[SumW-1]) begin
        pos_y_d = '0;
      end else if (sum_y[SumW-2:0] > {1'b0, y_lim}) begin
        pos_y_d = y_lim;
      end else begin
        pos_y_d = sum_y[POS_BITS-1:0];
      end
      buttons_d = {pkt_i.header[pmc_pkg::HDR_MIDDLE_BIT],
                   pkt_i.header[pmc_pkg::HDR_RIGHT_BIT],
                   pkt_i.header[pmc_pkg::HDR_LEFT_BIT]};
    end
  end

  // Cursor state and result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q     <= PosXRst;
      pos_y_q     <= PosYRst;
      buttons_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (take) begin
        pos_x_q   <= pos_x_d;
        pos_y_q   <= pos_y_d;
        buttons_q <= buttons_d;
      end
      if (pkt_ready_o) begin
        res_valid_q <= pkt_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      status_q <= status_d;
    end
  end

  // The state registers double as the result payload.
  assign x_ext = ExtW'(pos_x_q);
  assign y_ext = ExtW'(pos_y_q);

  assign res_o.valid          = res_valid_q;
  assign res_o.packet_status  = status_q;
  assign res_o.cursor_x       = x_ext[pmc_pkg::COORD_W-1:0];
  assign res_o.cursor_y       = y_ext[pmc_pkg::COORD_W-1:0];
  assign res_o.left_pressed   = buttons_q[0];
  assign res_o.right_pressed  = buttons_q[1];
  assign res_o.middle_pressed = buttons_q[2];

endmodule
